>>> hdl/sad_pkg.sv
package sad_pkg;

	// Default number of slots in the row of cells.
	localparam int DEPTH_DEF = 8;

	// Width of one held element.
	localparam int DATA_W = 32;

	// Operation codes carried by an input beat.
	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} sad_op_t;

	// Status codes carried by a result beat.
	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} sad_status_t;

	// Write command broadcast from the control to every cell.
	typedef struct packed {
		logic first_push;  // push into an empty deque, lands in slot zero
		logic add_front;   // accepted push front on a non-empty deque
		logic add_back;    // accepted push back on a non-empty deque
	} sad_cmd_t;

endpackage

>>> hdl/sad_cell.sv
module sad_cell #(
	parameter int DEPTH = sad_pkg::DEPTH_DEF,
	parameter int IDX   = 0
) (
	input  logic                           clk,
	input  sad_pkg::sad_cmd_t              cmd,
	input  logic [$clog2(DEPTH)-1:0]       front_pos,
	input  logic [$clog2(DEPTH)-1:0]       rear_pos,
	input  logic [sad_pkg::DATA_W-1:0]     data_value,
	input  logic [sad_pkg::DATA_W-1:0]     left_slot,
	output logic [sad_pkg::DATA_W-1:0]     slot,
	output logic [sad_pkg::DATA_W-1:0]     front_term,
	output logic [sad_pkg::DATA_W-1:0]     back_term
);

	localparam int PW = $clog2(DEPTH);

	logic [sad_pkg::DATA_W-1:0] slot_q;
	logic [PW:0]                my_idx;
	logic [PW:0]                front_ext;
	logic [PW:0]                rear_inc;
	logic                       load;
	logic                       shift;

	// Position compares against this cell's own index.
	assign my_idx    = (PW+1)'(IDX);
	assign front_ext = {1'b0, front_pos};
	assign rear_inc  = {1'b0, rear_pos} + (PW+1)'(1);

	// A push front moves every held element one slot up and writes at the front.
	assign load  = (cmd.first_push && (my_idx == '0))
		|| (cmd.add_front && (my_idx == front_ext))
		|| (cmd.add_back && (my_idx == rear_inc));
	assign shift = cmd.add_front && (my_idx > front_ext) && (my_idx <= rear_inc);

	// Slot storage; freed slots keep their contents.
	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= data_value;
		end else if (shift) begin
			slot_q <= left_slot;
		end
	end

	// Contributions to the front and back read-out.
	assign slot       = slot_q;
	assign front_term = (my_idx == front_ext) ? slot_q : '0;
	assign back_term  = (my_idx == {1'b0, rear_pos}) ? slot_q : '0;

endmodule

>>> hdl/shifting_array_deque.sv
// Double-ended queue held in a linear row of DEPTH slots.
// Input channel: in_valid / in_stall carry one operation per beat
// (push front, push back, pop front, pop back) with data_value for pushes.
// Output channel: out_valid / out_stall carry one result per input beat:
// status, is_empty, element_count, front_value and back_value after the
// operation; front and back read as zero when the deque is empty.
// The slots and positions update at the accepting edge; the operation then
// holds the busy stage while the front and back read-out through the cell row
// is registered into the result, and no new operation is taken while busy.
// A push is refused with overflow status while the rear sits in the last
// slot, even if pops at the front have left room; a pop on an empty deque
// gives underflow status.
// Reset clears the positions and marks the deque empty; slot contents are
// not cleared and are never read before being written.
// While the receiver stalls, the result is held and no new operation is
// taken until that result has left.
module shifting_array_deque #(
	parameter int DEPTH = sad_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       operation,
	input  logic signed [sad_pkg::DATA_W-1:0] data_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       status,
	output logic                             is_empty,
	output logic [$clog2(DEPTH+1)-1:0]       element_count,
	output logic signed [sad_pkg::DATA_W-1:0] front_value,
	output logic signed [sad_pkg::DATA_W-1:0] back_value
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);
	localparam int DW = sad_pkg::DATA_W;

	logic [PW-1:0]           front_q;
	logic [PW-1:0]           rear_q;
	logic                    empty_q;
	logic                    busy_q;
	logic                    out_valid_q;
	sad_pkg::sad_status_t    status_s1;
	logic [1:0]              status_q;
	logic                    is_empty_q;
	logic [CW-1:0]           count_q;
	logic [DW-1:0]           front_val_q;
	logic [DW-1:0]           back_val_q;

	logic                    accept;
	logic                    full;
	sad_pkg::sad_op_t        op;
	sad_pkg::sad_cmd_t       cmd;
	sad_pkg::sad_status_t    status_d;
	logic [PW-1:0]           front_d;
	logic [PW-1:0]           rear_d;
	logic                    empty_d;
	logic [DW-1:0]           front_or;
	logic [DW-1:0]           back_or;

	logic [DW-1:0]           slot_w  [DEPTH];
	logic [DW-1:0]           fterm_w [DEPTH];
	logic [DW-1:0]           bterm_w [DEPTH];

	// One operation at a time; the output register must be free for its result.
	assign in_stall = busy_q || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;
	assign full     = (rear_q == PW'(DEPTH-1));
	assign op       = sad_pkg::sad_op_t'(operation);

	// Operation decode: next positions, status and the cell write command.
	always_comb begin
		front_d  = front_q;
		rear_d   = rear_q;
		empty_d  = empty_q;
		status_d = sad_pkg::ST_DONE;
		cmd      = '0;
		unique case (op)
			sad_pkg::OP_PUSH_FRONT, sad_pkg::OP_PUSH_BACK: begin
				if (empty_q) begin
					front_d        = '0;
					rear_d         = '0;
					empty_d        = 1'b0;
					cmd.first_push = accept;
				end else if (full) begin
					status_d = sad_pkg::ST_OVERFLOW;
				end else begin
					rear_d = rear_q + PW'(1);
					if (op == sad_pkg::OP_PUSH_FRONT) begin
						cmd.add_front = accept;
					end else begin
						cmd.add_back = accept;
					end
				end
			end
			sad_pkg::OP_POP_FRONT, sad_pkg::OP_POP_BACK: begin
				if (empty_q) begin
					status_d = sad_pkg::ST_UNDERFLOW;
				end else if (front_q == rear_q) begin
					front_d = '0;
					rear_d  = '0;
					empty_d = 1'b1;
				end else if (op == sad_pkg::OP_POP_FRONT) begin
					front_d = front_q + PW'(1);
				end else begin
					rear_d = rear_q - PW'(1);
				end
			end
			default: begin
				status_d = sad_pkg::ST_DONE;
			end
		endcase
	end

	// Row of slot cells, each fed by its lower neighbor.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DW-1:0] left;
		if (i == 0) begin : g_first
			assign left = '0;
		end else begin : g_rest
			assign left = slot_w[i-1];
		end
		sad_cell #(
			.DEPTH(DEPTH),
			.IDX  (i)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.front_pos (front_q),
			.rear_pos  (rear_q),
			.data_value(data_value),
			.left_slot (left),
			.slot      (slot_w[i]),
			.front_term(fterm_w[i]),
			.back_term (bterm_w[i])
		);
	end

	// Gather the marked front and back slots from the row.
	always_comb begin
		front_or = '0;
		back_or  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			front_or = front_or | fterm_w[i];
			back_or  = back_or | bterm_w[i];
		end
	end

	// Control state: positions, empty flag and the busy stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			rear_q      <= '0;
			empty_q     <= 1'b1;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				front_q <= front_d;
				rear_q  <= rear_d;
				empty_q <= empty_d;
			end
			busy_q <= accept;
			if (busy_q) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Status of the operation in flight.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
		end
	end

	// Result register, loaded from the state left by the operation.
	always_ff @(posedge clk) begin
		if (busy_q) begin
			status_q    <= status_s1;
			is_empty_q  <= empty_q;
			count_q     <= empty_q ? '0 : (CW'(rear_q) - CW'(front_q) + CW'(1));
			front_val_q <= empty_q ? '0 : front_or;
			back_val_q  <= empty_q ? '0 : back_or;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign is_empty      = is_empty_q;
	assign element_count = count_q;
	assign front_value   = front_val_q;
	assign back_value    = back_val_q;

	// Each busy cycle is followed by a valid result.
	a_busy_result: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> out_valid_q)
		else $error("result not presented after operation");

	// No second operation enters while one is being read out.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("operation accepted while busy");

	// A non-empty deque never has its front above its rear.
	a_positions: assert property (@(posedge clk) disable iff (!arst_n)
		!empty_q |-> (front_q <= rear_q))
		else $error("front position above rear position");

	// The empty flag and the count agree on every result beat.
	a_count_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (element_count == '0)))
		else $error("empty flag disagrees with element count");

endmodule

>>> test/shifting_array_deque_tb.sv
`timescale 1ns / 100ps

module shifting_array_deque_tb;

	localparam int DEPTH       = sad_pkg::DEPTH_DEF;
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int HOLD_CYCLES = 80;
	localparam int STALL_LIMIT = 5000;
	localparam int PHASE_ITEMS = 270;

	// One operation waiting to be offered to the block.
	typedef struct {
		sad_pkg::sad_op_t   op;
		logic signed [31:0] value;
	} deque_op_t;

	// Deque outputs expected after one operation.
	typedef struct {
		sad_pkg::sad_status_t st;
		logic                 empty;
		logic [CNT_W-1:0]     count;
		logic signed [31:0]   front;
		logic signed [31:0]   back;
	} deque_view_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid;
	logic                     in_stall;
	logic [1:0]               operation;
	logic signed [31:0]       data_value;
	logic                     out_valid;
	logic                     out_stall;
	logic [1:0]               status;
	logic                     is_empty;
	logic [CNT_W-1:0]         element_count;
	logic signed [31:0]       front_value;
	logic signed [31:0]       back_value;

	deque_op_t   pending_ops[$];
	deque_view_t expected_views[$];

	// Predicted deque contents and positions.
	logic signed [31:0] shadow_slots [DEPTH];
	int                 shadow_front;
	int                 shadow_rear;
	bit                 shadow_empty;

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	bit hold_req = 1'b0;
	bit hold_done;
	int hold_count;
	int quiet_cycles;
	int err_count = 0;

	shifting_array_deque dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.data_value   (data_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.is_empty     (is_empty),
		.element_count(element_count),
		.front_value  (front_value),
		.back_value   (back_value)
	);

	always #10 clk = ~clk;

	// Applies one operation to the shadow deque and returns the view after it.
	function automatic deque_view_t deque_apply(sad_pkg::sad_op_t op, logic signed [31:0] v);
		deque_view_t r;
		bit at_front;
		r.st = sad_pkg::ST_DONE;
		at_front = (op == sad_pkg::OP_PUSH_FRONT) || (op == sad_pkg::OP_POP_FRONT);
		if (op == sad_pkg::OP_PUSH_FRONT || op == sad_pkg::OP_PUSH_BACK) begin
			if (shadow_empty) begin
				shadow_front = 0;
				shadow_rear = 0;
				shadow_slots[0] = v;
				shadow_empty = 1'b0;
			end else if (shadow_rear == DEPTH - 1) begin
				// The rear sits in the last slot, so the push is refused.
				r.st = sad_pkg::ST_OVERFLOW;
			end else if (at_front) begin
				for (int j = shadow_rear + 1; j > shadow_front; j--)
					shadow_slots[j] = shadow_slots[j - 1];
				shadow_rear++;
				shadow_slots[shadow_front] = v;
			end else begin
				shadow_rear++;
				shadow_slots[shadow_rear] = v;
			end
		end else begin
			if (shadow_empty) begin
				r.st = sad_pkg::ST_UNDERFLOW;
			end else if (shadow_front == shadow_rear) begin
				shadow_front = 0;
				shadow_rear = 0;
				shadow_empty = 1'b1;
			end else if (at_front) begin
				shadow_front++;
			end else begin
				shadow_rear--;
			end
		end
		r.empty = shadow_empty;
		r.count = shadow_empty ? '0 : CNT_W'(shadow_rear - shadow_front + 1);
		r.front = shadow_empty ? '0 : shadow_slots[shadow_front];
		r.back  = shadow_empty ? '0 : shadow_slots[shadow_rear];
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
		if (actv !== expv) begin
			err_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, expv, actv);
		end
	endtask

	// Driver: offers pending operations and predicts each accepted beat.
	always @(posedge clk or negedge arst_n) begin
		deque_op_t   next_op;
		deque_view_t new_view;
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= sad_pkg::OP_PUSH_FRONT;
			data_value <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				new_view = deque_apply(sad_pkg::sad_op_t'(operation), data_value);
				expected_views = {expected_views, new_view};
			end
			if (!in_valid || !in_stall) begin
				if (pending_ops.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
					next_op = pending_ops[0];
					pending_ops.delete(0);
					in_valid <= 1'b1;
					operation <= next_op.op;
					data_value <= next_op.value;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: drives the result stall, checks result beats, runs the watchdog.
	always @(posedge clk or negedge arst_n) begin
		deque_view_t exp_view;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_done <= 1'b0;
			hold_count <= 0;
			quiet_cycles <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_views.size() == 0) begin
					err_count++;
					$display("%0t: result beat with nothing expected, status %0d count %0d",
						$time, status, element_count);
				end else begin
					exp_view = expected_views[0];
					expected_views.delete(0);
					check_field("status", 32'(exp_view.st), 32'(status));
					check_field("is_empty", 32'(exp_view.empty), 32'(is_empty));
					check_field("element_count", 32'(exp_view.count), 32'(element_count));
					check_field("front_value", exp_view.front, front_value);
					check_field("back_value", exp_view.back, back_value);
				end
			end

			// A long hold-off stalls the result channel while the sender keeps offering operations.
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				hold_count <= hold_count + 1;
				if (hold_count == HOLD_CYCLES - 1)
					hold_done <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rx_stall_pct);
			end

			// Count cycles in which neither channel moves a beat.
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic add_op(sad_pkg::sad_op_t op, logic signed [31:0] v);
		deque_op_t item;
		item.op = op;
		item.value = v;
		pending_ops = {pending_ops, item};
	endtask

	// Random operations in bursts that lean toward filling, toward draining or to neither side.
	task automatic add_random_ops(int n);
		int push_pct;
		logic signed [31:0] v;
		push_pct = 50;
		for (int i = 0; i < n; i++) begin
			if (i % 30 == 0) begin
				case ($urandom_range(4))
					0: push_pct = 10;
					1: push_pct = 25;
					2: push_pct = 50;
					3: push_pct = 75;
					default: push_pct = 90;
				endcase
			end
			if ($urandom_range(7) == 0) begin
				case ($urandom_range(3))
					0: v = 32'h0000_0000;
					1: v = 32'hFFFF_FFFF;
					2: v = 32'h7FFF_FFFF;
					default: v = 32'h8000_0000;
				endcase
			end else begin
				v = $urandom;
			end
			if ($urandom_range(99) < push_pct)
				add_op(sad_pkg::sad_op_t'($urandom_range(1) ? sad_pkg::OP_PUSH_FRONT
					: sad_pkg::OP_PUSH_BACK), v);
			else
				add_op(sad_pkg::sad_op_t'($urandom_range(1) ? sad_pkg::OP_POP_FRONT
					: sad_pkg::OP_POP_BACK), v);
		end
	endtask

	task automatic wait_drained();
		while (pending_ops.size() != 0 || in_valid || expected_views.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_idling(int tx_pct, int rx_pct);
		@(negedge clk);
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
	endtask

	// Stimulus sequence.
	initial begin
		shadow_front = 0;
		shadow_rear = 0;
		shadow_empty = 1'b1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Pops on an empty deque, then single pushes removed from either end.
		add_op(sad_pkg::OP_POP_FRONT, 32'h1111_1111);
		add_op(sad_pkg::OP_POP_BACK, 32'h2222_2222);
		add_op(sad_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF);
		add_op(sad_pkg::OP_POP_BACK, 32'h0);
		add_op(sad_pkg::OP_PUSH_BACK, 32'h8000_0000);
		add_op(sad_pkg::OP_POP_FRONT, 32'h0);
		// Fill the deque from both ends, with front pushes shifting the row.
		add_op(sad_pkg::OP_PUSH_BACK, 32'h0000_0001);
		add_op(sad_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF);
		add_op(sad_pkg::OP_PUSH_BACK, 32'h0000_0000);
		add_op(sad_pkg::OP_PUSH_FRONT, 32'h8000_0000);
		add_op(sad_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF);
		add_op(sad_pkg::OP_PUSH_FRONT, 32'h5555_5555);
		add_op(sad_pkg::OP_PUSH_BACK, 32'hAAAA_AAAA);
		add_op(sad_pkg::OP_PUSH_FRONT, 32'h1234_5678);
		// Full: both pushes are refused.
		add_op(sad_pkg::OP_PUSH_BACK, 32'hDEAD_BEEF);
		add_op(sad_pkg::OP_PUSH_FRONT, 32'hCAFE_F00D);
		// A front pop frees a slot below the front, yet the rear still blocks.
		add_op(sad_pkg::OP_POP_FRONT, 32'h0);
		add_op(sad_pkg::OP_PUSH_BACK, 32'h0BAD_0BAD);
		add_op(sad_pkg::OP_POP_BACK, 32'h0);
		add_op(sad_pkg::OP_PUSH_FRONT, 32'h0F0F_0F0F);
		add_op(sad_pkg::OP_PUSH_FRONT, 32'hF0F0_F0F0);
		wait_drained();

		// No idling, with a long result hold-off partway through.
		add_random_ops(PHASE_ITEMS);
		repeat (40) @(posedge clk);
		@(negedge clk);
		hold_req = 1'b1;
		while (!hold_done)
			@(posedge clk);
		@(negedge clk);
		hold_req = 1'b0;
		wait_drained();

		set_idling(49, 0);
		add_random_ops(PHASE_ITEMS);
		wait_drained();

		set_idling(0, 49);
		add_random_ops(PHASE_ITEMS);
		wait_drained();

		set_idling(33, 33);
		add_random_ops(PHASE_ITEMS);
		wait_drained();

		set_idling(0, 0);
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
